// ===== rtl/core/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
// Used by mexp_ctrl, mexp_datapath and modular_exponentiation; depends on nothing.
package mexp_pkg;

   localparam int BASE_WIDTH      = 63;
   localparam int CSR_WIDTH       = 31;
   localparam int RESULT_WIDTH    = 31;
   localparam int RSP_TDATA_WIDTH = ((RESULT_WIDTH + 7) / 8) * 8;

   localparam logic [CSR_WIDTH-1:0] RESET_MODULUS = 31'd1000000007;

   // Controller to datapath
   typedef struct packed {
      logic load;         // capture a new word
      logic red_step;     // one bit of base reduction
      logic mul_init;     // clear the product and restart the bit count
      logic mul_step;     // one bit of shift-add modular multiply
      logic mul_sel_sqr;  // 1: base*base, 0: acc*base
      logic out_load;     // move the result into the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic exp_zero;
      logic exp_lsb;
      logic mod_zero;
      logic cnt_last;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/mexp_datapath.sv =====
// Datapath: modulus register, bit-serial base reducer, shared shift-add
// modular multiplier, exponent shifter and output register. Uses mexp_pkg.
module mexp_datapath #(
   parameter int MODULUS_WIDTH  = 31,
   parameter int EXPONENT_WIDTH = 63
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [mexp_pkg::CSR_WIDTH-1:0]        csr_wdata,
   input  logic [mexp_pkg::BASE_WIDTH-1:0]       in_base,
   input  logic [EXPONENT_WIDTH-1:0]             in_exponent,
   input  mexp_pkg::cmd_type                     cmd,
   output mexp_pkg::status_type                  status,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mexp_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata
);

   localparam int W   = MODULUS_WIDTH;
   localparam int BW  = mexp_pkg::BASE_WIDTH;
   localparam int CNT = $clog2(BW);

   logic [W-1:0]              modulus_ff, modulus_in;
   logic [W-1:0]              base_ff, base_in;
   logic [W-1:0]              acc_ff, acc_in;
   logic [W-1:0]              red_ff, red_in;
   logic [W-1:0]              prod_ff, prod_in;
   logic [W-1:0]              mul_y_ff, mul_y_in;
   logic [BW-1:0]             raw_ff, raw_in;
   logic [EXPONENT_WIDTH-1:0] exp_ff, exp_in;
   logic [CNT-1:0]            cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]              rsp_data_ff, rsp_data_in;

   logic [W:0]   mod_x;
   logic [W:0]   red_t;
   logic [W-1:0] red_next;
   logic [W:0]   dbl;
   logic [W-1:0] dbl_red;
   logic [W-1:0] mul_a;
   logic [W:0]   mul_sum;
   logic [W-1:0] prod_next;
   logic         out_free;

   assign mod_x = {1'b0, modulus_ff};

   // Restoring reduction: shift in one base bit, subtract once if needed
   assign red_t    = {red_ff, raw_ff[BW-1]};
   assign red_next = (red_t >= mod_x) ? W'(red_t - mod_x) : red_t[W-1:0];

   // Interleaved modular multiply, multiplier bits taken MSB first
   assign mul_a   = cmd.mul_sel_sqr ? base_ff : acc_ff;
   assign dbl     = {prod_ff, 1'b0};
   assign dbl_red = (dbl >= mod_x) ? W'(dbl - mod_x) : dbl[W-1:0];
   assign mul_sum = {1'b0, dbl_red} + (mul_y_ff[W-1] ? {1'b0, mul_a} : {(W+1){1'b0}});
   assign prod_next = (mul_sum >= mod_x) ? W'(mul_sum - mod_x) : mul_sum[W-1:0];

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      modulus_in   = modulus_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      red_in       = red_ff;
      prod_in      = prod_ff;
      mul_y_in     = mul_y_ff;
      raw_in       = raw_ff;
      exp_in       = exp_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_wen) begin
         modulus_in = csr_wdata[W-1:0];
      end

      if (cmd.load) begin
         raw_in = in_base;
         exp_in = in_exponent;
         red_in = '0;
         cnt_in = CNT'(BW - 1);
         // zero modulus gives 0 unless the exponent is zero
         acc_in = ((modulus_ff == '0) && (in_exponent != '0)) ? '0 : W'(1);
      end

      if (cmd.red_step) begin
         red_in = red_next;
         raw_in = {raw_ff[BW-2:0], 1'b0};
         cnt_in = cnt_ff - CNT'(1);
         if (cnt_ff == '0) begin
            base_in = red_next;
         end
      end

      if (cmd.mul_init) begin
         prod_in  = '0;
         cnt_in   = CNT'(W - 1);
         mul_y_in = base_ff;
      end

      if (cmd.mul_step) begin
         if (cnt_ff == '0) begin
            if (cmd.mul_sel_sqr) begin
               base_in = prod_next;
               exp_in  = exp_ff >> 1;
            end else begin
               acc_in = prod_next;
            end
            // restart for the squaring that follows a multiply
            prod_in  = '0;
            cnt_in   = CNT'(W - 1);
            mul_y_in = base_ff;
         end else begin
            prod_in  = prod_next;
            cnt_in   = cnt_ff - CNT'(1);
            mul_y_in = {mul_y_ff[W-2:0], 1'b0};
         end
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= mexp_pkg::RESET_MODULUS[W-1:0];
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      acc_ff      <= acc_in;
      red_ff      <= red_in;
      prod_ff     <= prod_in;
      mul_y_ff    <= mul_y_in;
      raw_ff      <= raw_in;
      exp_ff      <= exp_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.exp_zero = (exp_ff == '0);
   assign status.exp_lsb  = exp_ff[0];
   assign status.mod_zero = (modulus_ff == '0);
   assign status.cnt_last = (cnt_ff == '0);
   assign status.out_free = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = mexp_pkg::RSP_TDATA_WIDTH'(rsp_data_ff);

endmodule

// ===== rtl/core/mexp_ctrl.sv =====
// Controller state machine: sequences reduction, multiply and square passes.
// Uses mexp_pkg command and status types; drives mexp_datapath.
module mexp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  mexp_pkg::status_type status,
   output mexp_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_START  = 7'b0000010,
      ST_REDUCE = 7'b0000100,
      ST_LOOP   = 7'b0001000,
      ST_MUL    = 7'b0010000,
      ST_SQR    = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // take no word while reset is held
   assign req_tready = (state_ff == ST_IDLE) && !reset;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (status.exp_zero || status.mod_zero) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.red_step = 1'b1;
            if (status.cnt_last) begin
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            if (status.exp_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.mul_init = 1'b1;
               state_in     = status.exp_lsb ? ST_MUL : ST_SQR;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.cnt_last) begin
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            cmd.mul_step    = 1'b1;
            cmd.mul_sel_sqr = 1'b1;
            if (status.cnt_last) begin
               state_in = ST_LOOP;
            end
         end
         ST_DONE: begin
            // hold until the output register can take the word
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: base^exponent mod modulus.
// Instantiates mexp_ctrl and mexp_datapath; uses mexp_pkg.
//
// Usage:
//   req_* carries one word per item: base_value and exponent.
//   rsp_* returns one word per item: power_result.
//   csr_wen/csr_wdata write the modulus; write it only while the block is idle.
// One item is processed at a time. A zero exponent or zero modulus skips
// straight to the done state; otherwise the base is first reduced modulo
// the modulus bit by bit, then for each exponent bit up to the top set bit
// a multiply pass (only where the bit is set) and a squaring pass run on
// the single shared shift-add modular multiplier, one bit per cycle.
// The next word is accepted as soon as the result is handed to the output
// register, so a stalled receiver blocks only the item after that.
// Reset clears the controller and the output valid and loads the modulus
// with 1000000007 (truncated to MODULUS_WIDTH bits).
module modular_exponentiation #(
   parameter int MODULUS_WIDTH  = 31,
   parameter int EXPONENT_WIDTH = 63
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [mexp_pkg::CSR_WIDTH-1:0]        csr_wdata,   // modulus
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // base_value [62:0], exponent [62+EXPONENT_WIDTH:63], zero fill above
   input  logic [((mexp_pkg::BASE_WIDTH + EXPONENT_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // power_result [30:0], zero fill above
   output logic [mexp_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata
);

   localparam int BW = mexp_pkg::BASE_WIDTH;

   mexp_pkg::cmd_type    cmd;
   mexp_pkg::status_type status;

   mexp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mexp_datapath #(
      .MODULUS_WIDTH  (MODULUS_WIDTH),
      .EXPONENT_WIDTH (EXPONENT_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .in_base     (req_tdata[BW-1:0]),
      .in_exponent (req_tdata[BW+EXPONENT_WIDTH-1:BW]),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for modular_exponentiation: streams base/exponent words and
// checks each power_result word against a square-and-multiply predictor.
// Depends on mexp_pkg and the modular_exponentiation RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BASE_WIDTH      = mexp_pkg::BASE_WIDTH;
   localparam int CSR_WIDTH       = mexp_pkg::CSR_WIDTH;
   localparam int RESULT_WIDTH    = mexp_pkg::RESULT_WIDTH;
   localparam int RSP_TDATA_WIDTH = mexp_pkg::RSP_TDATA_WIDTH;

   localparam int EXP_WIDTH   = 63;
   localparam int REQ_WIDTH   = ((BASE_WIDTH + EXP_WIDTH + 7) / 8) * 8;
   localparam int IDLE_LIMIT  = 40000;
   localparam int HOLD_CYCLES = 3000;
   localparam int DRAIN_WAIT  = 4100;

   typedef enum int {
      RX_OPEN,
      RX_RANDOM,
      RX_PATTERN,
      RX_SPARSE
   } rx_mode_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_wen = 1'b0;
   logic [CSR_WIDTH-1:0]         csr_wdata = '0;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   // base_value [62:0], exponent [125:63], zero fill above
   logic [REQ_WIDTH-1:0]         req_tdata = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   // power_result [30:0], zero fill above
   logic [RSP_TDATA_WIDTH-1:0]   rsp_tdata;

   bit [RESULT_WIDTH-1:0] power_expected[$];
   bit [CSR_WIDTH-1:0]    modulus_now = mexp_pkg::RESET_MODULUS;
   int                    fail_count = 0;
   int                    burst_left = 0;
   int                    rx_hold_request = 0;

   modular_exponentiation #(
      .MODULUS_WIDTH (31),
      .EXPONENT_WIDTH(EXP_WIDTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Right-to-left square-and-multiply; products of two 31-bit residues fit in 64 bits.
   function automatic bit [RESULT_WIDTH-1:0] power_mod(bit [BASE_WIDTH-1:0] base,
                                                       bit [EXP_WIDTH-1:0] expo,
                                                       bit [CSR_WIDTH-1:0] modulus);
      bit [63:0] acc;
      bit [63:0] sq;
      bit [63:0] m;
      bit [EXP_WIDTH-1:0] bits;
      acc = 64'd1;
      if (expo != '0) begin
         if (modulus == '0) begin
            acc = 64'd0;
         end else begin
            m    = {33'd0, modulus};
            sq   = {1'b0, base} % m;
            bits = expo;
            while (bits != '0) begin
               if (bits[0]) begin
                  acc = (acc * sq) % m;
               end
               sq   = (sq * sq) % m;
               bits = bits >> 1;
            end
         end
      end
      return acc[RESULT_WIDTH-1:0];
   endfunction

   function automatic bit [62:0] rand_bits(int unsigned width);
      bit [63:0] v;
      v = {$urandom, $urandom};
      v = v & ((64'd1 << width) - 64'd1);
      return v[62:0];
   endfunction

   function automatic bit [BASE_WIDTH-1:0] rand_base();
      bit [63:0] v;
      case ($urandom_range(0, 7))
         0: v = 64'($urandom_range(0, 3));
         1: v = {33'd0, modulus_now} * 64'($urandom_range(0, 1000));
         2: v = {33'd0, modulus_now} - 64'd1;
         3: v = rand_bits($urandom_range(1, 63));
         default: v = rand_bits(63);
      endcase
      return v[BASE_WIDTH-1:0];
   endfunction

   function automatic bit [EXP_WIDTH-1:0] rand_exponent();
      case ($urandom_range(0, 7))
         0: return EXP_WIDTH'($urandom_range(0, 2));
         1, 2: return rand_bits($urandom_range(1, 16));
         3: return 63'd1 << $urandom_range(0, 62);
         default: return rand_bits(63);
      endcase
   endfunction

   // Offer one word in bursts with random gaps; record its result once accepted.
   task automatic send_word(input bit [BASE_WIDTH-1:0] base, input bit [EXP_WIDTH-1:0] expo);
      logic [REQ_WIDTH-1:0] word;
      int gap;
      word = '0;
      word[BASE_WIDTH-1:0] = base;
      word[BASE_WIDTH +: EXP_WIDTH] = expo;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      power_expected = {power_expected, power_mod(base, expo, modulus_now)};
   endtask

   // Stop offering and hold until every result word has come back.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (power_expected.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_modulus(input bit [CSR_WIDTH-1:0] value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen   <= 1'b0;
      modulus_now = value;
   endtask

   task automatic test_reset_modulus();
      send_word(63'd0, 63'd0);
      send_word(63'd2, 63'd10);
      send_word({63{1'b1}}, {63{1'b1}});
      send_word(63'd0, 63'd5);
      send_word(63'd1000000007, 63'd3);
      send_word(63'd1000000006, 63'd2);
      send_word({63{1'b1}}, 63'd0);
      send_word(63'd1000000008, 63'd1);
      wait_idle();
   endtask

   task automatic test_modulus_extremes();
      write_modulus(31'd1);
      send_word(63'd5, 63'd0);
      send_word(63'd5, 63'd7);
      send_word(63'd0, 63'd0);
      wait_idle();
      write_modulus({31{1'b1}});
      send_word(63'd2147483646, {63{1'b1}});
      send_word({63{1'b1}}, 63'd1);
      send_word(63'd1 << 62, 63'd1 << 62);
      send_word(63'h2AAAAAAAAAAAAAAA, 63'h5555555555555555);
      wait_idle();
      write_modulus(31'd2);
      send_word(63'd3, {63{1'b1}});
      send_word(63'd4, 63'd9);
      wait_idle();
      // zero modulus: one for a zero exponent, zero otherwise
      write_modulus(31'd0);
      send_word(63'd7, 63'd0);
      send_word(63'd7, 63'd3);
      send_word(63'd0, 63'd1);
      wait_idle();
   endtask

   task automatic test_random_phases();
      bit [CSR_WIDTH-1:0] m;
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: m = {31{1'b1}};
            1, 4: m = CSR_WIDTH'($urandom);
            2: m = CSR_WIDTH'($urandom_range(2, 64));
            3: m = 31'd1 << $urandom_range(1, 30);
            5: m = mexp_pkg::RESET_MODULUS;
            default: m = 31'd3;
         endcase
         write_modulus(m);
         for (int i = 0; i < 16; i++) begin
            send_word(rand_base(), rand_exponent());
         end
         wait_idle();
      end
   endtask

   // Hold the receiver off while words keep coming so the input stalls.
   task automatic test_receiver_hold();
      write_modulus(CSR_WIDTH'($urandom));
      @(posedge clock);
      rx_hold_request = HOLD_CYCLES;
      for (int i = 0; i < 6; i++) begin
         send_word(rand_bits(63), rand_bits(8));
      end
      wait_idle();
   endtask

   // Receiver: switch stall style now and then; a hold request overrides it.
   initial begin
      rx_mode_type mode;
      int          mode_left;
      int          hold_left;
      int          tick;
      bit [7:0]    pattern;
      mode      = RX_OPEN;
      mode_left = 100;
      hold_left = 0;
      tick      = 0;
      pattern   = 8'hFF;
      forever begin
         @(negedge clock);
         tick++;
         if (rx_hold_request != 0) begin
            hold_left = rx_hold_request;
            rx_hold_request = 0;
         end
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 400);
            pattern   = 8'($urandom);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               RX_OPEN:    rsp_tready <= 1'b1;
               RX_RANDOM:  rsp_tready <= ($urandom_range(0, 2) != 0);
               RX_PATTERN: rsp_tready <= pattern[3'(tick)] | (pattern == 8'h00);
               default:    rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (power_expected.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got %0d",
                     $time, rsp_tdata[RESULT_WIDTH-1:0]);
            fail_count++;
         end else begin
            if (rsp_tdata[RESULT_WIDTH-1:0] != power_expected[0]) begin
               $display("%0t: power_result mismatch, expected %0d, got %0d",
                        $time, power_expected[0], rsp_tdata[RESULT_WIDTH-1:0]);
               fail_count++;
            end
            void'(power_expected.pop_front());
         end
      end
   end

   // Watchdog: end the run after too many cycles without any accepted word.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("%0t: timeout, no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_modulus();
      test_modulus_extremes();
      test_receiver_hold();
      test_random_phases();
      wait_idle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (power_expected.size() != 0) begin
         $display("%0t: %0d result words never arrived, expected %0d, got none",
                  $time, power_expected.size(), power_expected[0]);
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
